// ----- rtl/core/bffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants and control types of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int OPCODE_W        = 1;
    localparam int COUNT_W         = 7;
    localparam int BN_W            = 11;

    localparam int NUM_BLOCKS_DEF  = 1024;
    localparam int MAX_REQUEST_DEF = 64;

    // free map word width: wide words for normal maps, narrow for tiny ones
    localparam int WORD_W_WIDE     = 64;
    localparam int WORD_W_NARROW   = 8;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic restart;   // word pointer back to word 0
        logic start;     // capture requested count
        logic clr_wr;    // write a zero word, step pointer
        logic rd;        // read current word
        logic ld;        // load read word into scan register
        logic grant;     // take lowest free bit of scan register
        logic wb;        // write scan register back, step pointer
        logic fin;       // emit final result of an allocation
        logic ack;       // emit a bare acknowledgement
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic word_last;
        logic has_free;
        logic grant_last;
        logic slot_free;
    } t_sts;

endpackage

// ----- rtl/core/bffa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_req_if / bffa_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface bffa_req_if;
    logic                           valid;
    logic                           ready;
    logic [bffa_pkg::OPCODE_W-1:0]  opcode;
    logic [bffa_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output opcode, output count, input ready);
    modport sink   (input valid, input opcode, input count, output ready);
endinterface

interface bffa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bffa_pkg::BN_W-1:0]  block_number;
    logic                       last;
    logic                       shortfall;

    modport source (output valid, output block_number, output last, output shortfall,
                    input ready);
    modport sink   (input valid, input block_number, input last, input shortfall,
                    output ready);
endinterface

// ----- rtl/core/bitmap_first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator
// First-fit allocator over a one-bit-per-block free map.
//
// Request channel i_req carries opcode and count; response channel o_rsp
// returns block_number, last and shortfall, both valid/ready. An allocate
// returns one response per granted block (1-based number, lowest first),
// last on the final one, shortfall if the grant fell short. Zero count,
// clear and a full map return a single response with block_number 0.
// The map lives in a memory of 64-bit words (8-bit for maps under 64
// blocks); NUM_BLOCKS/64 = 16 words by default.
// Sequence: each word visited passes through a read, a load and a scan;
// the scan grants blocks from the word while the output register can take
// a response and otherwise waits, and a final step places the last
// response. A clear writes every word to zero and then acknowledges; a
// zero count goes straight to the acknowledgement. One request is in flight
// at a time; a new request is taken once the previous one has placed its
// last response in the output register.
// Reset: a clearing pass writes every word to free; i_req.ready stays low
// until it is done. A stalled receiver holds the output register and the
// scan waits for it.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator #(
    parameter int NUM_BLOCKS  = bffa_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_REQUEST = bffa_pkg::MAX_REQUEST_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bffa_req_if.sink   i_req,
    bffa_rsp_if.source o_rsp
);

    bffa_pkg::t_cmd w_cmd;
    bffa_pkg::t_sts w_sts;
    logic           w_req_ready;
    logic           w_req_clear;
    logic           w_req_zero;

    assign w_req_clear = (i_req.opcode == bffa_pkg::OP_CLEAR);
    assign w_req_zero  = (i_req.count == '0);
    assign i_req.ready = w_req_ready;

    bffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_clear (w_req_clear),
        .i_req_zero  (w_req_zero),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bffa_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_count            (i_req.count),
        .i_rsp_ready        (o_rsp.ready),
        .o_rsp_valid        (o_rsp.valid),
        .o_rsp_block_number (o_rsp.block_number),
        .o_rsp_last         (o_rsp.last),
        .o_rsp_shortfall    (o_rsp.shortfall)
    );

    // only the final response may carry no block
    a_mid_has_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.last |-> o_rsp.block_number != '0)
        else $error("non-final response without a block number");

    a_sf_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.shortfall |-> o_rsp.last)
        else $error("shortfall on a non-final response");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while another is in progress");

endmodule

// ----- rtl/core/bffa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer: clearing sweep, word read/scan/write-back loop, result emission.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_clear,
    input  logic              i_req_zero,
    output logic              o_req_ready,
    input  bffa_pkg::t_sts    i_sts,
    output bffa_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_CLR  = 8'b0000_0100,
        S_ACK  = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_LD   = 8'b0010_0000,
        S_SCAN = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.word_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.restart = 1'b1;
                    if (i_req_clear) begin
                        n_state = S_CLR;
                    end else if (i_req_zero) begin
                        n_state = S_ACK;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RD;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.word_last) begin
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (i_sts.slot_free) begin
                    o_cmd.ack = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LD;
            end
            S_LD: begin
                o_cmd.ld = 1'b1;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.has_free) begin
                    if (i_sts.slot_free) begin
                        o_cmd.grant = 1'b1;
                        if (i_sts.grant_last) begin
                            o_cmd.wb = 1'b1;
                            n_state  = S_FIN;
                        end
                    end
                end else begin
                    // word exhausted: store it and move on
                    o_cmd.wb = 1'b1;
                    n_state  = i_sts.word_last ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (i_sts.slot_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// ----- rtl/core/bffa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_dp
// Free map memory, scan word with lowest-free-bit encoder, counts, result reg.
// ----------------------------------------------------------------------------
module bffa_dp #(
    parameter int NUM_BLOCKS  = bffa_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_REQUEST = bffa_pkg::MAX_REQUEST_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bffa_pkg::t_cmd                 i_cmd,
    output bffa_pkg::t_sts                 o_sts,
    input  logic [bffa_pkg::COUNT_W-1:0]   i_count,
    input  logic                           i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic [bffa_pkg::BN_W-1:0]      o_rsp_block_number,
    output logic                           o_rsp_last,
    output logic                           o_rsp_shortfall
);

    localparam int W      = (NUM_BLOCKS < bffa_pkg::WORD_W_WIDE) ?
                            bffa_pkg::WORD_W_NARROW : bffa_pkg::WORD_W_WIDE;
    localparam int BW     = $clog2(W);
    localparam int NWORDS = (NUM_BLOCKS + W - 1) / W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int TAIL   = NUM_BLOCKS - (NWORDS - 1) * W;
    localparam int CW     = $clog2(MAX_REQUEST + 1);
    localparam int BNW    = bffa_pkg::BN_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    logic [W-1:0]   r_mem [NWORDS];
    logic [W-1:0]   r_rd;
    logic [W-1:0]   r_cur;
    logic [W-1:0]   n_cur;
    logic [W-1:0]   tail_mask;
    logic [AW-1:0]  r_word;
    logic [CW-1:0]  r_want;
    logic [CW-1:0]  r_got;
    logic [CW-1:0]  want_sat;
    logic           r_pend_vld;
    logic [BNW-1:0] r_pend_bn;
    logic           r_out_vld;
    logic [BNW-1:0] r_out_bn;
    logic           r_out_last;
    logic           r_out_sf;

    logic           has_free;
    logic [BW-1:0]  free_idx;
    logic [31:0]    bn_full;
    logic [BNW-1:0] bn;
    logic           word_last;
    logic           grant_last;
    logic           emit;
    logic [BNW-1:0] emit_bn;
    logic           emit_last;
    logic           emit_sf;

    assign word_last = (r_word == LAST_WORD);

    // bits past the end of the map read as used
    always_comb begin
        for (int b = 0; b < W; b++) begin
            tail_mask[b] = word_last && (b >= TAIL);
        end
    end

    // lowest zero bit of the scan word
    always_comb begin
        has_free = 1'b0;
        free_idx = '0;
        for (int b = W - 1; b >= 0; b--) begin
            if (!r_cur[b]) begin
                has_free = 1'b1;
                free_idx = BW'(b);
            end
        end
    end

    assign n_cur      = r_cur | (W'(1) << free_idx);
    assign bn_full    = 32'({r_word, free_idx}) + 32'd1;
    assign bn         = bn_full[BNW-1:0];
    assign grant_last = (({1'b0, r_got} + {{CW{1'b0}}, 1'b1}) == {1'b0, r_want});
    assign want_sat   = (i_count > bffa_pkg::COUNT_W'(MAX_REQUEST)) ?
                        CW'(MAX_REQUEST) : i_count[CW-1:0];

    // free map memory: one write or one read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_word] <= '0;
        end else if (i_cmd.wb) begin
            r_mem[r_word] <= i_cmd.grant ? n_cur : r_cur;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_cur <= r_rd | tail_mask;
        end else if (i_cmd.grant) begin
            r_cur <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_cmd.restart) begin
            r_word <= '0;
        end else if (i_cmd.clr_wr || i_cmd.wb) begin
            r_word <= word_last ? '0 : r_word + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_want <= want_sat;
            r_got  <= '0;
        end else if (i_cmd.grant) begin
            r_got  <= r_got + CW'(1);
        end
    end

    // one grant is held back so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.grant) begin
            r_pend_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grant) begin
            r_pend_bn <= bn;
        end
    end

    always_comb begin
        emit      = 1'b0;
        emit_bn   = '0;
        emit_last = 1'b0;
        emit_sf   = 1'b0;
        if (i_cmd.ack) begin
            emit      = 1'b1;
            emit_last = 1'b1;
        end else if (i_cmd.fin) begin
            emit      = 1'b1;
            emit_bn   = r_pend_vld ? r_pend_bn : '0;
            emit_last = 1'b1;
            emit_sf   = (r_got != r_want);
        end else if (i_cmd.grant) begin
            if (r_pend_vld) begin
                emit      = 1'b1;
                emit_bn   = r_pend_bn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_bn   <= emit_bn;
            r_out_last <= emit_last;
            r_out_sf   <= emit_sf;
        end
    end

    assign o_rsp_valid        = r_out_vld;
    assign o_rsp_block_number = r_out_bn;
    assign o_rsp_last         = r_out_last;
    assign o_rsp_shortfall    = r_out_sf;

    assign o_sts.word_last  = word_last;
    assign o_sts.has_free   = has_free;
    assign o_sts.grant_last = grant_last;
    assign o_sts.slot_free  = !r_out_vld || i_rsp_ready;

endmodule
